>>> sv/tnab_pkg.sv
// Shared constants and types for the triangle setup pipeline.
// No dependencies; used by triangle_normal_and_bounds.
package tnab_pkg;

  localparam int COORD_BITS       = 24;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int NORM_BITS        = NORMAL_FRAC_BITS + 2;
  localparam int MAT_BITS         = 10;

  localparam int EDGE_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int POS_W   = 6;
  localparam int SCALE_W = 31;
  localparam int SQ_W    = 2 * SCALE_W;
  localparam int SUM_W   = 64;
  localparam int ROOT_W  = 32;
  localparam int TRY_W   = SUM_W + 2;
  localparam int Q_W     = NORMAL_FRAC_BITS + 2;
  localparam int NUM_W   = SCALE_W + NORMAL_FRAC_BITS + 3;
  localparam int DIV_W   = NUM_W + 2;

  // register stages before the root, root steps, divider steps
  localparam int FRONT_STAGES = 9;
  localparam int ROOT_STAGES  = ROOT_W;
  localparam int DIV_STAGES   = Q_W;
  localparam int LINE_LEN     = FRONT_STAGES + ROOT_STAGES + 1 + DIV_STAGES;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t [2:0]        lo;
    coord_t [2:0]        hi;
    logic [MAT_BITS-1:0] mat;
  } aux_t;

  typedef struct packed {
    logic [2:0][SCALE_W-1:0] m;
    logic [2:0]              neg;
    logic                    deg;
  } geom_t;

endpackage

>>> sv/triangle_normal_and_bounds.sv
// Triangle setup pipeline: unit face normal, bounding box, material copy.
// Depends on tnab_pkg.
//
// One triangle may be started in every clock cycle; busy is always low and
// the receiver cannot stall, so nothing is ever held back. Each transaction
// gives exactly one result, marked by out_valid for one cycle, after
// tnab_pkg::LINE_LEN + 1 register stages. That depth is set by the chain
// of units: edges, six 25x25 products, cross sum, magnitude,
// leading-one search and scaling, three 31x31 squares, sum, a 32-step
// bit-per-stage square root and three 16-step bit-per-stage dividers.
// Results leave in the order the triangles came in. A zero cross product
// sets out_degenerate and gives a zero normal; box and material still valid.
module triangle_normal_and_bounds (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [tnab_pkg::COORD_BITS-1:0] in_a_x,
  input  logic signed [tnab_pkg::COORD_BITS-1:0] in_a_y,
  input  logic signed [tnab_pkg::COORD_BITS-1:0] in_a_z,
  input  logic signed [tnab_pkg::COORD_BITS-1:0] in_b_x,
  input  logic signed [tnab_pkg::COORD_BITS-1:0] in_b_y,
  input  logic signed [tnab_pkg::COORD_BITS-1:0] in_b_z,
  input  logic signed [tnab_pkg::COORD_BITS-1:0] in_c_x,
  input  logic signed [tnab_pkg::COORD_BITS-1:0] in_c_y,
  input  logic signed [tnab_pkg::COORD_BITS-1:0] in_c_z,
  input  logic        [tnab_pkg::MAT_BITS-1:0]   in_mat_in,
  output logic                                  out_valid,
  output logic signed [tnab_pkg::NORM_BITS-1:0]  out_norm_x,
  output logic signed [tnab_pkg::NORM_BITS-1:0]  out_norm_y,
  output logic signed [tnab_pkg::NORM_BITS-1:0]  out_norm_z,
  output logic signed [tnab_pkg::COORD_BITS-1:0] out_box_lo_x,
  output logic signed [tnab_pkg::COORD_BITS-1:0] out_box_lo_y,
  output logic signed [tnab_pkg::COORD_BITS-1:0] out_box_lo_z,
  output logic signed [tnab_pkg::COORD_BITS-1:0] out_box_hi_x,
  output logic signed [tnab_pkg::COORD_BITS-1:0] out_box_hi_y,
  output logic signed [tnab_pkg::COORD_BITS-1:0] out_box_hi_z,
  output logic        [tnab_pkg::MAT_BITS-1:0]   out_mat_out,
  output logic                                  out_degenerate
);

  localparam int EW  = tnab_pkg::EDGE_W;
  localparam int PW  = tnab_pkg::PROD_W;
  localparam int XW  = tnab_pkg::CROSS_W;
  localparam int SW  = tnab_pkg::SCALE_W;
  localparam int RW  = tnab_pkg::ROOT_W;
  localparam int TW  = tnab_pkg::TRY_W;
  localparam int DW  = tnab_pkg::DIV_W;
  localparam int QW  = tnab_pkg::Q_W;
  localparam int NF  = tnab_pkg::NORMAL_FRAC_BITS;
  localparam int NB  = tnab_pkg::NORM_BITS;
  localparam int LL  = tnab_pkg::LINE_LEN;
  localparam int RS  = tnab_pkg::ROOT_STAGES;
  localparam int DS  = tnab_pkg::DIV_STAGES;

  // the pipeline never stalls
  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // valid bits and pass-through data travel on their own delay line
  logic [LL-1:0]       vld_r;
  tnab_pkg::aux_t      aux_r [LL];
  tnab_pkg::aux_t      aux_nxt;

  tnab_pkg::coord_t va [3];
  tnab_pkg::coord_t vb [3];
  tnab_pkg::coord_t vc [3];

  assign va[0] = in_a_x; assign va[1] = in_a_y; assign va[2] = in_a_z;
  assign vb[0] = in_b_x; assign vb[1] = in_b_y; assign vb[2] = in_b_z;
  assign vc[0] = in_c_x; assign vc[1] = in_c_y; assign vc[2] = in_c_z;

  always_comb begin
    tnab_pkg::coord_t lo_ab;
    tnab_pkg::coord_t hi_ab;
    aux_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      lo_ab = (va[k] < vb[k]) ? va[k] : vb[k];
      hi_ab = (va[k] > vb[k]) ? va[k] : vb[k];
      aux_nxt.lo[k] = (lo_ab < vc[k]) ? lo_ab : vc[k];
      aux_nxt.hi[k] = (hi_ab > vc[k]) ? hi_ab : vc[k];
    end
    aux_nxt.mat = in_mat_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LL-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    aux_r[0] <= aux_nxt;
    for (int s = 1; s < LL; s++) aux_r[s] <= aux_r[s-1];
  end

  // stage 1: edges
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      e1_r[k] <= EW'(vb[k]) - EW'(va[k]);
      e2_r[k] <= EW'(vc[k]) - EW'(va[k]);
    end
  end

  // stage 2: six products
  logic signed [PW-1:0] p_r [6];

  always_ff @(posedge clk) begin
    p_r[0] <= PW'(e1_r[1]) * PW'(e2_r[2]);
    p_r[1] <= PW'(e1_r[2]) * PW'(e2_r[1]);
    p_r[2] <= PW'(e1_r[2]) * PW'(e2_r[0]);
    p_r[3] <= PW'(e1_r[0]) * PW'(e2_r[2]);
    p_r[4] <= PW'(e1_r[0]) * PW'(e2_r[1]);
    p_r[5] <= PW'(e1_r[1]) * PW'(e2_r[0]);
  end

  // stage 3: cross product
  logic signed [XW-1:0] n_r [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      n_r[k] <= XW'(p_r[2*k]) - XW'(p_r[2*k+1]);
    end
  end

  // stage 4: magnitudes and signs
  logic [XW-1:0] mag4_r [3];
  logic [2:0]    neg4_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      mag4_r[k] <= n_r[k][XW-1] ? XW'(-n_r[k]) : XW'(n_r[k]);
      neg4_r[k] <= n_r[k][XW-1];
    end
  end

  // stage 5: largest magnitude
  logic [XW-1:0] mag5_r [3];
  logic [XW-1:0] mx5_r;
  logic [2:0]    neg5_r;
  logic [XW-1:0] mx_nxt;

  always_comb begin
    mx_nxt = (mag4_r[0] > mag4_r[1]) ? mag4_r[0] : mag4_r[1];
    if (mag4_r[2] > mx_nxt) mx_nxt = mag4_r[2];
  end

  always_ff @(posedge clk) begin
    mag5_r <= mag4_r;
    mx5_r  <= mx_nxt;
    neg5_r <= neg4_r;
  end

  // stage 6: leading-one position of the largest magnitude, degenerate check
  logic [XW-1:0]               mag6_r [3];
  logic [tnab_pkg::POS_W-1:0]  pos6_r;
  logic [tnab_pkg::POS_W-1:0]  pos_nxt;
  logic [2:0]                  neg6_r;
  logic                        deg6_r;

  always_comb begin
    pos_nxt = '0;
    for (int b = 0; b < XW; b++) begin
      if (mx5_r[b]) pos_nxt = tnab_pkg::POS_W'(b);
    end
  end

  always_ff @(posedge clk) begin
    mag6_r <= mag5_r;
    pos6_r <= pos_nxt;
    neg6_r <= neg5_r;
    deg6_r <= (mx5_r == '0);
  end

  // stage 7: scale so the largest sits in [2^30, 2^31)
  tnab_pkg::geom_t g7_r;
  tnab_pkg::geom_t g7_nxt;

  always_comb begin
    g7_nxt     = '0;
    g7_nxt.neg = neg6_r;
    g7_nxt.deg = deg6_r;
    for (int k = 0; k < 3; k++) begin
      if (pos6_r >= tnab_pkg::POS_W'(SW - 1)) begin
        g7_nxt.m[k] = SW'(mag6_r[k] >> (pos6_r - tnab_pkg::POS_W'(SW - 1)));
      end else begin
        g7_nxt.m[k] = SW'(mag6_r[k] << (tnab_pkg::POS_W'(SW - 1) - pos6_r));
      end
    end
  end

  always_ff @(posedge clk) g7_r <= g7_nxt;

  // stage 8: squares
  tnab_pkg::geom_t                 g8_r;
  logic [tnab_pkg::SQ_W-1:0]       sq8_r [3];

  always_ff @(posedge clk) begin
    g8_r <= g7_r;
    for (int k = 0; k < 3; k++) begin
      sq8_r[k] <= tnab_pkg::SQ_W'(g7_r.m[k]) * tnab_pkg::SQ_W'(g7_r.m[k]);
    end
  end

  // stage 9: sum of squares
  tnab_pkg::geom_t               g9_r;
  logic [tnab_pkg::SUM_W-1:0]    sum9_r;

  always_ff @(posedge clk) begin
    g9_r   <= g8_r;
    sum9_r <= tnab_pkg::SUM_W'(sq8_r[0]) + tnab_pkg::SUM_W'(sq8_r[1])
            + tnab_pkg::SUM_W'(sq8_r[2]);
  end

  // square root, one result bit per stage, most significant first
  tnab_pkg::geom_t            rg_r   [RS];
  logic [tnab_pkg::SUM_W-1:0] rrem_r [RS];
  logic [RW-1:0]              root_r [RS];

  for (genvar k = 0; k < RS; k++) begin : g_root
    localparam int BIT = RS - 1 - k;
    tnab_pkg::geom_t            g_in;
    logic [tnab_pkg::SUM_W-1:0] rem_in;
    logic [RW-1:0]              root_in;
    logic [TW-1:0]              trial;

    if (k == 0) begin : g_first
      assign g_in    = g9_r;
      assign rem_in  = sum9_r;
      assign root_in = '0;
    end else begin : g_next
      assign g_in    = rg_r[k-1];
      assign rem_in  = rrem_r[k-1];
      assign root_in = root_r[k-1];
    end

    assign trial = (TW'(root_in) << (BIT + 1)) | (TW'(1) << (2 * BIT));

    always_ff @(posedge clk) begin
      rg_r[k] <= g_in;
      if (TW'(rem_in) >= trial) begin
        rrem_r[k] <= tnab_pkg::SUM_W'(TW'(rem_in) - trial);
        root_r[k] <= root_in | (RW'(1) << BIT);
      end else begin
        rrem_r[k] <= rem_in;
        root_r[k] <= root_in;
      end
    end
  end

  // divider set-up: numerator m * 2^F + floor(L / 2), rounds half up
  tnab_pkg::geom_t gi_r;
  logic [RW-1:0]   len_r;
  logic [DW-1:0]   num_r [3];

  always_ff @(posedge clk) begin
    gi_r  <= rg_r[RS-1];
    len_r <= root_r[RS-1];
    for (int k = 0; k < 3; k++) begin
      num_r[k] <= (DW'(rg_r[RS-1].m[k]) << NF) + DW'(root_r[RS-1] >> 1);
    end
  end

  // three restoring dividers, one quotient bit per stage
  tnab_pkg::geom_t dg_r   [DS];
  logic [RW-1:0]   dlen_r [DS];
  logic [DW-1:0]   drem_r [DS][3];
  logic [QW-1:0]   quo_r  [DS][3];

  for (genvar j = 0; j < DS; j++) begin : g_div
    localparam int BIT = DS - 1 - j;
    tnab_pkg::geom_t g_in;
    logic [RW-1:0]   len_in;
    logic [DW-1:0]   rem_in [3];
    logic [QW-1:0]   q_in   [3];
    logic [DW-1:0]   dvs;

    if (j == 0) begin : g_first
      assign g_in   = gi_r;
      assign len_in = len_r;
      for (genvar k = 0; k < 3; k++) begin : g_lane
        assign rem_in[k] = num_r[k];
        assign q_in[k]   = '0;
      end
    end else begin : g_next
      assign g_in   = dg_r[j-1];
      assign len_in = dlen_r[j-1];
      for (genvar k = 0; k < 3; k++) begin : g_lane
        assign rem_in[k] = drem_r[j-1][k];
        assign q_in[k]   = quo_r[j-1][k];
      end
    end

    assign dvs = DW'(len_in) << BIT;

    always_ff @(posedge clk) begin
      dg_r[j]   <= g_in;
      dlen_r[j] <= len_in;
      for (int k = 0; k < 3; k++) begin
        if (rem_in[k] >= dvs) begin
          drem_r[j][k] <= rem_in[k] - dvs;
          quo_r[j][k]  <= q_in[k] | (QW'(1) << BIT);
        end else begin
          drem_r[j][k] <= rem_in[k];
          quo_r[j][k]  <= q_in[k];
        end
      end
    end
  end

  // output: saturate, apply sign, zero on degenerate
  logic signed [NB-1:0] norm_nxt [3];

  always_comb begin
    logic [QW-1:0] q;
    for (int k = 0; k < 3; k++) begin
      q = quo_r[DS-1][k];
      if (q > (QW'(1) << NF)) q = QW'(1) << NF;
      if (dg_r[DS-1].deg) begin
        norm_nxt[k] = '0;
      end else if (dg_r[DS-1].neg[k]) begin
        norm_nxt[k] = NB'(-q);
      end else begin
        norm_nxt[k] = NB'(q);
      end
    end
  end

  logic                 out_valid_r;
  logic signed [NB-1:0] norm_r [3];
  tnab_pkg::aux_t       aux_out_r;
  logic                 deg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[LL-1];
    end
  end

  always_ff @(posedge clk) begin
    norm_r    <= norm_nxt;
    aux_out_r <= aux_r[LL-1];
    deg_r     <= dg_r[DS-1].deg;
  end

  assign out_valid      = out_valid_r;
  assign out_norm_x     = norm_r[0];
  assign out_norm_y     = norm_r[1];
  assign out_norm_z     = norm_r[2];
  assign out_box_lo_x   = aux_out_r.lo[0];
  assign out_box_lo_y   = aux_out_r.lo[1];
  assign out_box_lo_z   = aux_out_r.lo[2];
  assign out_box_hi_x   = aux_out_r.hi[0];
  assign out_box_hi_y   = aux_out_r.hi[1];
  assign out_box_hi_z   = aux_out_r.hi[2];
  assign out_mat_out    = aux_out_r.mat;
  assign out_degenerate = deg_r;

endmodule
